>>> hdl/bounded_list_engine_assert.svh
// Assertion macros for the bounded list engine.
// Used by the top level only; no other dependencies.
`ifndef BOUNDED_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_LIST_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define BLE_ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define BLE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define BLE_ASSERT_IMPLIES(label, clk, rst, pre, post)
`define BLE_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

>>> hdl/ble_pkg.sv
// Types and codes shared by the bounded list engine.
// No dependencies.
package ble_pkg;
   localparam logic [2:0] REQ_APPEND  = 3'd0;
   localparam logic [2:0] REQ_REMOVE  = 3'd1;
   localparam logic [2:0] REQ_DEDUP   = 3'd2;
   localparam logic [2:0] REQ_PALIN   = 3'd3;
   localparam logic [2:0] REQ_READOUT = 3'd4;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BADIDX = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [31:0] value;
      logic [7:0]         index;
   } req_type_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] value_res;
      logic               pal_flag;
      logic               last;
   } rsp_type;
endpackage

>>> hdl/ble_mem.sv
// Entry memory of the bounded list engine: one write port, two read ports,
// read data registered. Depends on nothing.
module ble_mem #(
   parameter int DEPTH = 32,
   parameter int AW = 5
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [31:0]   wdata,
   input  logic [AW-1:0] raddr_a,
   input  logic [AW-1:0] raddr_b,
   output logic [31:0]   rdata_a,
   output logic [31:0]   rdata_b
);
   logic [31:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a <= mem_ff[raddr_a];
      rdata_b <= mem_ff[raddr_b];
   end
endmodule

>>> hdl/bounded_list_engine.sv
// Top level of the bounded list engine: sequencer plus entry memory.
// Depends on ble_pkg, ble_mem and bounded_list_engine_assert.svh.
//
// Usage: one request item enters on req_ (valid/ready); results leave on
// rsp_ (valid/ready), each with a last mark. One request is worked at a
// time; req_ready is high only while the sequencer is idle.
// Append completes on acceptance; remove shifts the later entries down
// one by one; palindrome compares entry pairs from both ends; read out
// sends one result per entry (an empty mark when empty) and waits on
// receiver stalls; duplicate removal compares each entry with those kept
// so far, then runs a read out. Each step is one memory read followed by
// a compare or write-back. A result waits in the rsp_ register while the
// receiver stalls; the sequencer holds until it is taken.
// Reset empties the list (count cleared); memory contents are left as is
// and never used before being written.
`include "bounded_list_engine_assert.svh"
module bounded_list_engine
   import ble_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_RM_RD, S_RM_SH, S_PA_RD, S_PA_CMP,
      S_DD_RD, S_DD_CMP, S_RO_RD, S_RO_OUT, S_WAIT
   } state_type;

   state_type   state_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] i_ff, j_ff, kept_ff;
   logic [31:0] val_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic          we;
   logic [AW-1:0] waddr, ra, rb;
   logic [31:0]   wdata, rda, rdb;
   logic          rsp_load;

   ble_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr_a(ra), .raddr_b(rb), .rdata_a(rda), .rdata_b(rdb)
   );

   logic out_free;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic req_acc;
   logic app_full;
   logic rm_bad;
   logic [CW-1:0] start_i;
   assign req_acc  = req_valid && req_ready;
   assign app_full = !(count_ff < CW'(DEPTH));
   assign rm_bad   = req_data.index == 8'd0 || {1'b0, req_data.index} > 9'(count_ff);
   assign start_i  = (req_data.req_type == REQ_REMOVE) ? CW'(req_data.index - 8'd1) : '0;

   logic [CW-1:0] i_next;
   logic [CW-1:0] pal_hi;
   logic          pal_done;
   assign i_next   = i_ff + CW'(1);
   assign pal_hi   = count_ff - CW'(1) - i_ff;
   assign pal_done = ({i_ff, 1'b0} + (CW+1)'(2)) > {1'b0, count_ff};

   always_comb begin
      we = 1'b0;
      waddr = count_ff[AW-1:0];
      wdata = req_data.value;
      ra = i_ff[AW-1:0];
      rb = j_ff[AW-1:0];
      rsp_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            we = req_acc && req_data.req_type == REQ_APPEND && !app_full;
            rsp_load = req_acc && ((req_data.req_type == REQ_APPEND && app_full)
               || (req_data.req_type == REQ_REMOVE && rm_bad));
         end
         S_RM_RD: rb = i_next[AW-1:0];
         S_RM_SH: begin
            we = i_next < count_ff;
            waddr = i_ff[AW-1:0];
            wdata = rdb;
            rsp_load = !(i_next < count_ff);
         end
         S_PA_RD: begin
            rb = pal_hi[AW-1:0];
            rsp_load = pal_done;
         end
         S_PA_CMP: rsp_load = rda != rdb;
         S_DD_CMP: begin
            we = (j_ff >= kept_ff);
            waddr = kept_ff[AW-1:0];
            wdata = rda;
         end
         S_RO_RD: rsp_load = count_ff == '0;
         S_RO_OUT: rsp_load = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         i_ff <= '0;
         j_ff <= '0;
         kept_ff <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  i_ff <= start_i;
                  j_ff <= start_i;
                  kept_ff <= '0;
                  case (req_data.req_type)
                     REQ_APPEND: begin
                        if (!app_full) begin
                           count_ff <= count_ff + CW'(1);
                        end else begin
                           rsp_ff <= '{status: ST_FULL, value_res: '0,
                                       pal_flag: 1'b0, last: 1'b1};
                        end
                     end
                     REQ_REMOVE: begin
                        if (rm_bad) begin
                           rsp_ff <= '{status: ST_BADIDX, value_res: '0,
                                       pal_flag: 1'b0, last: 1'b1};
                        end else begin
                           state_ff <= S_RM_RD;
                        end
                     end
                     REQ_DEDUP: state_ff <= S_DD_RD;
                     REQ_PALIN: state_ff <= S_PA_RD;
                     REQ_READOUT: state_ff <= S_RO_RD;
                     default: ;
                  endcase
               end
            end
            S_RM_RD: state_ff <= S_RM_SH;
            S_RM_SH: begin
               if (i_ff == j_ff) begin
                  val_ff <= rda;
               end
               if (i_next < count_ff) begin
                  i_ff <= i_next;
                  state_ff <= S_RM_RD;
               end else begin
                  count_ff <= count_ff - CW'(1);
                  rsp_ff <= '{status: ST_OK, value_res: (i_ff == j_ff) ? rda : val_ff,
                              pal_flag: 1'b0, last: 1'b1};
                  state_ff <= S_WAIT;
               end
            end
            S_PA_RD: begin
               if (pal_done) begin
                  rsp_ff <= '{status: ST_OK, value_res: '0, pal_flag: 1'b1, last: 1'b1};
                  state_ff <= S_WAIT;
               end else begin
                  state_ff <= S_PA_CMP;
               end
            end
            S_PA_CMP: begin
               if (rda != rdb) begin
                  rsp_ff <= '{status: ST_OK, value_res: '0, pal_flag: 1'b0, last: 1'b1};
                  state_ff <= S_WAIT;
               end else begin
                  i_ff <= i_next;
                  state_ff <= S_PA_RD;
               end
            end
            S_DD_RD: begin
               if (i_ff >= count_ff) begin
                  count_ff <= kept_ff;
                  i_ff <= '0;
                  state_ff <= S_RO_RD;
               end else begin
                  state_ff <= S_DD_CMP;
               end
            end
            S_DD_CMP: begin
               if (j_ff >= kept_ff) begin
                  kept_ff <= kept_ff + CW'(1);
                  i_ff <= i_next;
                  j_ff <= '0;
               end else if (rda == rdb) begin
                  i_ff <= i_next;
                  j_ff <= '0;
               end else begin
                  j_ff <= j_ff + CW'(1);
               end
               state_ff <= S_DD_RD;
            end
            S_RO_RD: begin
               if (count_ff == '0) begin
                  rsp_ff <= '{status: ST_EMPTY, value_res: '0, pal_flag: 1'b0, last: 1'b1};
                  state_ff <= S_WAIT;
               end else begin
                  state_ff <= S_RO_OUT;
               end
            end
            S_RO_OUT: begin
               if (out_free) begin
                  rsp_ff <= '{status: ST_OK, value_res: rda, pal_flag: 1'b0,
                              last: i_next == count_ff};
                  if (i_next == count_ff) begin
                     state_ff <= S_WAIT;
                  end else begin
                     i_ff <= i_next;
                     state_ff <= S_RO_RD;
                  end
               end
            end
            S_WAIT: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `BLE_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `BLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `BLE_ASSERT_IMPLIES(a_busy_no_req, clock, reset, state_ff != S_IDLE, !req_ready)
endmodule

>>> tb/tb_bounded_list_engine.sv
// Testbench for the bounded list engine: drives request items, predicts results with a
// behavioral list model and checks each result item in order. Depends on ble_pkg and the RTL.
`timescale 1ns / 1ps
module tb_bounded_list_engine;
   import ble_pkg::*;

   localparam int DEPTH = 32;
   localparam int LIMIT = 2000000;

   logic         clock;
   logic         reset;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_type_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_type      rsp_data;

   bounded_list_engine #(.DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   req_type_type pending_items[$];
   rsp_type      expected_rsp[$];
   logic [31:0]  list_vals[DEPTH];
   int           list_len = 0;
   int           errors = 0;
   int           cycles = 0;
   int           send_idle_pct;
   int           recv_stall_pct;
   bit           hold_request;
   bit           hold_seen;
   bit           hold_off;
   int           hold_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic rsp_type mk(input logic [1:0] st, input logic [31:0] v,
                                  input logic pal, input logic lst);
      rsp_type r;
      r.status = st;
      r.value_res = v;
      r.pal_flag = pal;
      r.last = lst;
      return r;
   endfunction

   task automatic push_readout();
      if (list_len == 0) begin
         expected_rsp.push_back(mk(ST_EMPTY, '0, 1'b0, 1'b1));
      end else begin
         for (int i = 0; i < list_len; i++)
            expected_rsp.push_back(mk(ST_OK, list_vals[i], 1'b0, i == list_len - 1));
      end
   endtask

   task automatic predict_list(input req_type_type it);
      int kept;
      bit seen;
      bit pal;
      logic [31:0] v;
      case (it.req_type)
         REQ_APPEND: begin
            if (list_len >= DEPTH) expected_rsp.push_back(mk(ST_FULL, '0, 1'b0, 1'b1));
            else begin
               list_vals[list_len] = it.value;
               list_len++;
            end
         end
         REQ_REMOVE: begin
            if (list_len == 0 || it.index < 1 || it.index > list_len) begin
               expected_rsp.push_back(mk(ST_BADIDX, '0, 1'b0, 1'b1));
            end else begin
               v = list_vals[it.index - 1];
               for (int i = it.index - 1; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
               list_len--;
               expected_rsp.push_back(mk(ST_OK, v, 1'b0, 1'b1));
            end
         end
         REQ_DEDUP: begin
            kept = 0;
            for (int i = 0; i < list_len; i++) begin
               seen = 0;
               for (int j = 0; j < kept; j++) if (list_vals[j] == list_vals[i]) seen = 1;
               if (!seen) begin
                  list_vals[kept] = list_vals[i];
                  kept++;
               end
            end
            list_len = kept;
            push_readout();
         end
         REQ_PALIN: begin
            pal = 1;
            for (int i = 0; i < list_len / 2; i++)
               if (list_vals[i] != list_vals[list_len - 1 - i]) pal = 0;
            expected_rsp.push_back(mk(ST_OK, '0, pal, 1'b1));
         end
         REQ_READOUT: push_readout();
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) predict_list(req_data);
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      cycles++;
      if (cycles > LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            report($sformatf("unexpected result %p", rsp_data));
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_data.status !== e.status)
               report($sformatf("status %0d exp %0d", rsp_data.status, e.status));
            if (rsp_data.value_res !== e.value_res)
               report($sformatf("value %h exp %h", rsp_data.value_res, e.value_res));
            if (rsp_data.pal_flag !== e.pal_flag)
               report($sformatf("palindrome %b exp %b", rsp_data.pal_flag,
                                e.pal_flag));
            if (rsp_data.last !== e.last)
               report($sformatf("last %b exp %b", rsp_data.last, e.last));
         end
      end
      rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_request && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_off <= 1'b1;
         hold_cycles <= 0;
      end else if (hold_off) begin
         hold_cycles <= hold_cycles + 1;
         if (hold_cycles >= 400) hold_off <= 1'b0;
      end
   end

   function automatic req_type_type item(input logic [2:0] t, input logic [31:0] v,
                                         input logic [7:0] ix);
      req_type_type r;
      r.req_type = t;
      r.value = v;
      r.index = ix;
      return r;
   endfunction

   task automatic add_random(input int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 40)
            pending_items.push_back(item(REQ_APPEND,
               ($urandom_range(2) == 0) ? $urandom : $urandom_range(3), 8'($urandom)));
         else if (k < 60)
            pending_items.push_back(item(REQ_REMOVE, $urandom,
               ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(12))));
         else if (k < 70)
            pending_items.push_back(item(REQ_DEDUP, $urandom, 8'($urandom)));
         else if (k < 82)
            pending_items.push_back(item(REQ_PALIN, $urandom, 8'($urandom)));
         else if (k < 94)
            pending_items.push_back(item(REQ_READOUT, $urandom, 8'($urandom)));
         else
            pending_items.push_back(item(3'($urandom_range(7, 5)), $urandom, 8'($urandom)));
      end
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while ((pending_items.size() > 0 || req_valid || expected_rsp.size() > 0)
             && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (100) @(posedge clock);
   endtask

   initial begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      pending_items.push_back(item(REQ_READOUT, '0, '0));
      pending_items.push_back(item(REQ_PALIN, '0, '0));
      pending_items.push_back(item(REQ_REMOVE, '0, 8'd1));
      pending_items.push_back(item(REQ_DEDUP, '0, '0));
      pending_items.push_back(item(REQ_APPEND, 32'h8000_0000, 8'hff));
      pending_items.push_back(item(REQ_PALIN, '0, '0));
      pending_items.push_back(item(REQ_APPEND, 32'h7fff_ffff, '0));
      pending_items.push_back(item(REQ_APPEND, 32'h8000_0000, '0));
      pending_items.push_back(item(REQ_APPEND, 32'hffff_ffff, '0));
      pending_items.push_back(item(REQ_PALIN, '0, '0));
      pending_items.push_back(item(REQ_REMOVE, '0, 8'd0));
      pending_items.push_back(item(REQ_REMOVE, '0, 8'hff));
      pending_items.push_back(item(REQ_REMOVE, '0, 8'd4));
      pending_items.push_back(item(REQ_REMOVE, '0, 8'd3));
      pending_items.push_back(item(3'd7, 32'hffff_ffff, 8'hff));
      pending_items.push_back(item(REQ_READOUT, '0, '0));
      for (int i = 0; i < DEPTH; i++) pending_items.push_back(item(REQ_APPEND, 32'(i % 5), '0));
      pending_items.push_back(item(REQ_APPEND, 32'd1, '0));
      pending_items.push_back(item(REQ_DEDUP, '0, '0));
      drain();

      add_random(25);
      drain();
      send_idle_pct = 88;
      add_random(25);
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 88;
      add_random(25);
      drain();
      send_idle_pct = 36;
      recv_stall_pct = 36;
      hold_request = 1'b1;
      add_random(25);
      drain();

      if (expected_rsp.size() > 0) report("results still expected at end");
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
